FILE: rtl/core/glob_pattern_matcher_top_defines.svh
// ---------------------------------------------------------------------------
// glob pattern matcher assertion macros
// shared property forms for the port checker
// ---------------------------------------------------------------------------
`ifndef GLOB_PATTERN_MATCHER_TOP_DEFINES_SVH
`define GLOB_PATTERN_MATCHER_TOP_DEFINES_SVH

// same-cycle implication
`define GPM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define GPM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/gpm_pkg.sv
// ---------------------------------------------------------------------------
// gpm_pkg
// beat types, action codes and glob syntax bytes for the matcher
// ---------------------------------------------------------------------------
`default_nettype none

package gpm_pkg;

    localparam logic [1:0] ACT_PATTERN  = 2'd0;
    localparam logic [1:0] ACT_SUBJECT  = 2'd1;
    localparam logic [1:0] ACT_EVALUATE = 2'd2;

    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_OPEN   = 8'h5B;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_CLOSE  = 8'h5D;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CASE_OFFSET = 8'h20;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] byte_value;
    } item_t;

    typedef struct packed {
        logic matched;
        logic overflowed;
    } result_t;

    typedef struct packed {
        logic       pat_we;
        logic       subj_we;
        logic [7:0] data;
    } load_cmd_t;

    function automatic logic [7:0] fold_ascii(input logic [7:0] c);
        if (c >= CH_UPPER_A && c <= CH_UPPER_Z)
        begin
            return c + CASE_OFFSET;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/gpm_store.sv
// ---------------------------------------------------------------------------
// gpm_store
// pattern and subject memories with fill counts and overflow flag
// ---------------------------------------------------------------------------
`default_nettype none

module gpm_store #(
    parameter int PATTERN_DEPTH = 64,
    parameter int SUBJECT_DEPTH = 256,
    parameter int PCW = $clog2(PATTERN_DEPTH + 1),
    parameter int SCW = $clog2(SUBJECT_DEPTH + 1),
    parameter int PAW = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1,
    parameter int SAW = (SUBJECT_DEPTH > 1) ? $clog2(SUBJECT_DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire gpm_pkg::load_cmd_t cmd,
    input  wire logic              clear,
    input  wire logic [PAW-1:0]    pat_raddr,
    input  wire logic [SAW-1:0]    subj_raddr,
    output logic      [7:0]        pat_rdata,
    output logic      [7:0]        subj_rdata,
    output logic      [PCW-1:0]    pat_count,
    output logic      [SCW-1:0]    subj_count,
    output logic                   overflow
);

    localparam logic [PCW-1:0] PAT_FULL  = PCW'(PATTERN_DEPTH);
    localparam logic [SCW-1:0] SUBJ_FULL = SCW'(SUBJECT_DEPTH);

    logic [7:0] pat_mem  [PATTERN_DEPTH];
    logic [7:0] subj_mem [SUBJECT_DEPTH];

    logic [PCW-1:0] pat_count_reg, pat_count_next;
    logic [SCW-1:0] subj_count_reg, subj_count_next;
    logic           overflow_reg, overflow_next;
    logic           pat_wr, subj_wr;

    always_comb
    begin
        pat_wr          = cmd.pat_we && (pat_count_reg != PAT_FULL);
        subj_wr         = cmd.subj_we && (subj_count_reg != SUBJ_FULL);
        pat_count_next  = pat_count_reg;
        subj_count_next = subj_count_reg;
        overflow_next   = overflow_reg;
        if (clear)
        begin
            pat_count_next  = '0;
            subj_count_next = '0;
            overflow_next   = 1'b0;
        end
        else
        begin
            if (pat_wr)
            begin
                pat_count_next = pat_count_reg + 1'b1;
            end
            if (subj_wr)
            begin
                subj_count_next = subj_count_reg + 1'b1;
            end
            if ((cmd.pat_we && !pat_wr) || (cmd.subj_we && !subj_wr))
            begin
                overflow_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_count_reg  <= '0;
            subj_count_reg <= '0;
            overflow_reg   <= 1'b0;
        end
        else
        begin
            pat_count_reg  <= pat_count_next;
            subj_count_reg <= subj_count_next;
            overflow_reg   <= overflow_next;
        end
    end

    // pattern memory
    always_ff @(posedge clk)
    begin
        if (pat_wr)
        begin
            pat_mem[pat_count_reg[PAW-1:0]] <= cmd.data;
        end
        pat_rdata <= pat_mem[pat_raddr];
    end

    // subject memory
    always_ff @(posedge clk)
    begin
        if (subj_wr)
        begin
            subj_mem[subj_count_reg[SAW-1:0]] <= cmd.data;
        end
        subj_rdata <= subj_mem[subj_raddr];
    end

    assign pat_count  = pat_count_reg;
    assign subj_count = subj_count_reg;
    assign overflow   = overflow_reg;

endmodule

`default_nettype wire

FILE: rtl/core/gpm_engine.sv
// ---------------------------------------------------------------------------
// gpm_engine
// sequencer that walks pattern and subject stores with star backtracking
// ---------------------------------------------------------------------------
`default_nettype none

module gpm_engine #(
    parameter int PATTERN_DEPTH = 64,
    parameter int SUBJECT_DEPTH = 256,
    parameter int PCW = $clog2(PATTERN_DEPTH + 1),
    parameter int SCW = $clog2(SUBJECT_DEPTH + 1),
    parameter int PAW = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1,
    parameter int SAW = (SUBJECT_DEPTH > 1) ? $clog2(SUBJECT_DEPTH) : 1
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire logic           nocase,
    input  wire logic [PCW-1:0] pat_count,
    input  wire logic [SCW-1:0] subj_count,
    input  wire logic [7:0]     pat_rdata,
    input  wire logic [7:0]     subj_rdata,
    output logic      [PAW-1:0] pat_raddr,
    output logic      [SAW-1:0] subj_raddr,
    output logic                idle,
    output logic                done,
    output logic                matched
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_FETCH  = 4'd1;
    localparam logic [3:0] ST_DECIDE = 4'd2;
    localparam logic [3:0] ST_C_RD   = 4'd3;
    localparam logic [3:0] ST_C_B0   = 4'd4;
    localparam logic [3:0] ST_C_B1   = 4'd5;
    localparam logic [3:0] ST_C_B2   = 4'd6;
    localparam logic [3:0] ST_T_RD   = 4'd7;
    localparam logic [3:0] ST_T_CHK  = 4'd8;
    localparam logic [3:0] ST_DONE   = 4'd9;

    logic [3:0]     state_reg, state_next;
    logic [PCW-1:0] p_reg, p_next;
    logic [SCW-1:0] s_reg, s_next;
    logic           star_reg, star_next;
    logic [PCW-1:0] star_at_reg, star_at_next;
    logic [SCW-1:0] resume_reg, resume_next;
    logic [PCW-1:0] cp_reg, cp_next;
    logic [7:0]     c_reg, c_next;
    logic [7:0]     b0_reg, b0_next;
    logic           inv_reg, inv_next;
    logic           found_reg, found_next;
    logic           first_reg, first_next;
    logic           match_reg, match_next;

    logic           fail;
    logic           lit;
    logic [PCW:0]   cp_plus2;

    always_comb
    begin
        lit      = nocase ? (gpm_pkg::fold_ascii(pat_rdata) == gpm_pkg::fold_ascii(subj_rdata))
                          : (pat_rdata == subj_rdata);
        cp_plus2 = {1'b0, cp_reg} + (PCW+1)'(2);
    end

    // read addresses, data arrives in the following state
    always_comb
    begin
        case (state_reg)
            ST_C_RD:  pat_raddr = cp_reg[PAW-1:0];
            ST_C_B0:  pat_raddr = PAW'(cp_reg + 1'b1);
            ST_C_B1:  pat_raddr = PAW'(cp_reg + PCW'(2));
            default:  pat_raddr = p_reg[PAW-1:0];
        endcase
        subj_raddr = s_reg[SAW-1:0];
    end

    always_comb
    begin
        state_next   = state_reg;
        p_next       = p_reg;
        s_next       = s_reg;
        star_next    = star_reg;
        star_at_next = star_at_reg;
        resume_next  = resume_reg;
        cp_next      = cp_reg;
        c_next       = c_reg;
        b0_next      = b0_reg;
        inv_next     = inv_reg;
        found_next   = found_reg;
        first_next   = first_reg;
        match_next   = match_reg;
        fail         = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    p_next     = '0;
                    s_next     = '0;
                    star_next  = 1'b0;
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                state_next = (s_reg >= subj_count) ? ST_T_RD : ST_DECIDE;
            end
            ST_DECIDE:
            begin
                c_next = subj_rdata;
                if (p_reg >= pat_count)
                begin
                    fail = 1'b1;
                end
                else if (pat_rdata == gpm_pkg::CH_STAR)
                begin
                    star_next    = 1'b1;
                    star_at_next = p_reg;
                    resume_next  = s_reg;
                    p_next       = p_reg + 1'b1;
                    state_next   = ST_FETCH;
                end
                else if (pat_rdata == gpm_pkg::CH_QMARK || lit)
                begin
                    p_next     = p_reg + 1'b1;
                    s_next     = s_reg + 1'b1;
                    state_next = ST_FETCH;
                end
                else if (pat_rdata == gpm_pkg::CH_OPEN)
                begin
                    cp_next    = p_reg + 1'b1;
                    inv_next   = 1'b0;
                    found_next = 1'b0;
                    first_next = 1'b1;
                    state_next = ST_C_RD;
                end
                else
                begin
                    fail = 1'b1;
                end
            end
            ST_C_RD:
            begin
                if (cp_reg >= pat_count)
                begin
                    fail = 1'b1;
                end
                else
                begin
                    state_next = ST_C_B0;
                end
            end
            ST_C_B0:
            begin
                first_next = 1'b0;
                b0_next    = pat_rdata;
                if (first_reg && pat_rdata == gpm_pkg::CH_CARET)
                begin
                    inv_next   = 1'b1;
                    cp_next    = cp_reg + 1'b1;
                    state_next = ST_C_RD;
                end
                else if (pat_rdata == gpm_pkg::CH_CLOSE)
                begin
                    if (found_reg ^ inv_reg)
                    begin
                        p_next     = cp_reg + 1'b1;
                        s_next     = s_reg + 1'b1;
                        state_next = ST_FETCH;
                    end
                    else
                    begin
                        fail = 1'b1;
                    end
                end
                else if (cp_plus2 < {1'b0, pat_count})
                begin
                    state_next = ST_C_B1;
                end
                else
                begin
                    if (pat_rdata == c_reg)
                    begin
                        found_next = 1'b1;
                    end
                    cp_next    = cp_reg + 1'b1;
                    state_next = ST_C_RD;
                end
            end
            ST_C_B1:
            begin
                if (pat_rdata == gpm_pkg::CH_DASH)
                begin
                    state_next = ST_C_B2;
                end
                else
                begin
                    if (b0_reg == c_reg)
                    begin
                        found_next = 1'b1;
                    end
                    cp_next    = cp_reg + 1'b1;
                    state_next = ST_C_RD;
                end
            end
            ST_C_B2:
            begin
                if (c_reg >= b0_reg && c_reg <= pat_rdata)
                begin
                    found_next = 1'b1;
                end
                cp_next    = PCW'(cp_plus2 + 1'b1);
                state_next = ST_C_RD;
            end
            ST_T_RD:
            begin
                if (p_reg < pat_count)
                begin
                    state_next = ST_T_CHK;
                end
                else
                begin
                    match_next = 1'b1;
                    state_next = ST_DONE;
                end
            end
            ST_T_CHK:
            begin
                if (pat_rdata == gpm_pkg::CH_STAR)
                begin
                    p_next     = p_reg + 1'b1;
                    state_next = ST_T_RD;
                end
                else
                begin
                    match_next = 1'b0;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // mismatch: back to the last star, which swallows one more byte
        if (fail)
        begin
            if (star_reg)
            begin
                p_next      = star_at_reg + 1'b1;
                resume_next = resume_reg + 1'b1;
                s_next      = resume_reg + 1'b1;
                state_next  = ST_FETCH;
            end
            else
            begin
                match_next = 1'b0;
                state_next = ST_DONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            star_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            star_reg  <= star_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg       <= p_next;
        s_reg       <= s_next;
        star_at_reg <= star_at_next;
        resume_reg  <= resume_next;
        cp_reg      <= cp_next;
        c_reg       <= c_next;
        b0_reg      <= b0_next;
        inv_reg     <= inv_next;
        found_reg   <= found_next;
        first_reg   <= first_next;
        match_reg   <= match_next;
    end

    assign idle    = (state_reg == ST_IDLE);
    assign done    = (state_reg == ST_DONE);
    assign matched = match_reg;

endmodule

`default_nettype wire

FILE: rtl/core/glob_pattern_matcher_top.sv
// ---------------------------------------------------------------------------
// glob_pattern_matcher_top
// glob matcher with '*', '?', literal and bracket class support
// ---------------------------------------------------------------------------
//  channel  | handshake                  | payload
//  ---------+----------------------------+-----------------------------------
//  item     | item_valid / item_ready    | item   (action, byte_value)
//  result   | result_valid / result_ready| result (matched, overflowed)
//  config   | cfg_wr_en                  | cfg_wr_data (case_insensitive)
//
//  a load can follow every cycle while the engine is idle, also while a result waits
//  evaluate: each compare step sends the address, then uses the registered read
//  data; class elements and trailing stars are read byte by byte, then come an
//  end check and finish; the single read port of each memory sets the step time
//  backtracking to the last star repeats steps, up to pattern x subject of them
//  reset clears counts, flag and sequencer at once, no clearing pass; an
//  evaluate beat waits while an earlier result is still unclaimed
// ---------------------------------------------------------------------------
`default_nettype none

module glob_pattern_matcher_top #(
    parameter int PATTERN_DEPTH = 64,
    parameter int SUBJECT_DEPTH = 256
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    output logic                  item_ready,
    input  wire gpm_pkg::item_t   item,
    output logic                  result_valid,
    input  wire logic             result_ready,
    output gpm_pkg::result_t      result,
    input  wire logic             cfg_wr_en,
    input  wire logic             cfg_wr_data
);

    localparam int PCW = $clog2(PATTERN_DEPTH + 1);
    localparam int SCW = $clog2(SUBJECT_DEPTH + 1);
    localparam int PAW = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;
    localparam int SAW = (SUBJECT_DEPTH > 1) ? $clog2(SUBJECT_DEPTH) : 1;

    logic               nocase_reg;
    logic               result_valid_reg, result_valid_next;
    gpm_pkg::result_t   result_reg;

    logic               accept;
    logic               start;
    gpm_pkg::load_cmd_t load_cmd;

    logic [PAW-1:0]     pat_raddr;
    logic [SAW-1:0]     subj_raddr;
    logic [7:0]         pat_rdata;
    logic [7:0]         subj_rdata;
    logic [PCW-1:0]     pat_count;
    logic [SCW-1:0]     subj_count;
    logic               overflow;
    logic               eng_idle;
    logic               eng_done;
    logic               eng_matched;

    // evaluate must not overrun an unclaimed result
    assign item_ready = eng_idle &&
                        (!result_valid_reg || (item.action != gpm_pkg::ACT_EVALUATE));
    assign accept     = item_valid && item_ready;
    assign start      = accept && (item.action == gpm_pkg::ACT_EVALUATE);

    always_comb
    begin
        load_cmd.pat_we  = accept && (item.action == gpm_pkg::ACT_PATTERN);
        load_cmd.subj_we = accept && (item.action == gpm_pkg::ACT_SUBJECT);
        load_cmd.data    = item.byte_value;
    end

    gpm_store #(
        .PATTERN_DEPTH (PATTERN_DEPTH),
        .SUBJECT_DEPTH (SUBJECT_DEPTH)
    ) u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (load_cmd),
        .clear      (eng_done),
        .pat_raddr  (pat_raddr),
        .subj_raddr (subj_raddr),
        .pat_rdata  (pat_rdata),
        .subj_rdata (subj_rdata),
        .pat_count  (pat_count),
        .subj_count (subj_count),
        .overflow   (overflow)
    );

    gpm_engine #(
        .PATTERN_DEPTH (PATTERN_DEPTH),
        .SUBJECT_DEPTH (SUBJECT_DEPTH)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .nocase     (nocase_reg),
        .pat_count  (pat_count),
        .subj_count (subj_count),
        .pat_rdata  (pat_rdata),
        .subj_rdata (subj_rdata),
        .pat_raddr  (pat_raddr),
        .subj_raddr (subj_raddr),
        .idle       (eng_idle),
        .done       (eng_done),
        .matched    (eng_matched)
    );

    // output register: set on finish, cleared when the beat is taken
    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (result_valid_reg && result_ready)
        begin
            result_valid_next = 1'b0;
        end
        if (eng_done)
        begin
            result_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nocase_reg       <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
            if (cfg_wr_en)
            begin
                nocase_reg <= cfg_wr_data;
            end
        end
    end

    // flag is sampled before the store clears it on the same edge
    always_ff @(posedge clk)
    begin
        if (eng_done)
        begin
            result_reg.matched    <= eng_matched;
            result_reg.overflowed <= overflow;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire

FILE: rtl/core/gpm_checker.sv
// ---------------------------------------------------------------------------
// gpm_checker
// port-level checks on the matcher, bound to the top level
// ---------------------------------------------------------------------------
`default_nettype none

`include "glob_pattern_matcher_top_defines.svh"

module gpm_checker (
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             item_valid,
    input wire logic             item_ready,
    input wire gpm_pkg::item_t   item,
    input wire logic             result_valid,
    input wire logic             result_ready,
    input wire gpm_pkg::result_t result
);

    logic eval_beat;

    assign eval_beat = item_valid && item_ready && (item.action == gpm_pkg::ACT_EVALUATE);

    `GPM_ASSERT_NEXT(a_result_hold, clk, rst_n, result_valid && !result_ready, result_valid && $stable(result), "result beat dropped or changed while stalled")
    `GPM_ASSERT_NEXT(a_busy_after_eval, clk, rst_n, eval_beat, !item_ready && !result_valid, "matcher not busy after evaluate beat")
    `GPM_ASSERT_NOW(a_no_eval_overrun, clk, rst_n, result_valid && item_valid && (item.action == gpm_pkg::ACT_EVALUATE), !item_ready, "evaluate taken over unclaimed result")
    `GPM_ASSERT_NOW(a_result_from_walk, clk, rst_n, $rose(result_valid), $past(!item_ready), "result appeared without a walk")

endmodule

bind glob_pattern_matcher_top gpm_checker u_gpm_checker (.*);

`default_nettype wire
